[hw/rtl/ptw_pkg.sv]
// ----------------------------------------------------------------------------
// ptw_pkg
// Shared types and constants of the four-level page table walker: request
// and result beats, walk states, request and status codes, entry bits.
// ----------------------------------------------------------------------------
package ptw_pkg;

    localparam int unsigned TABLE_PAGES_DEF   = 64;
    localparam int unsigned ENTRIES_PER_TABLE = 512;
    localparam int unsigned IDX_BITS          = 9;
    localparam int unsigned PAGE_SHIFT        = 12;
    localparam int unsigned LARGE_SHIFT       = 21;
    localparam int unsigned FLAG_BITS         = 5;
    localparam int unsigned CANON_MSB         = 47;

    // index field position of each level in the virtual address
    localparam int unsigned L4_LSB = 39;
    localparam int unsigned L3_LSB = 30;
    localparam int unsigned L2_LSB = 21;
    localparam int unsigned L1_LSB = 12;

    localparam int unsigned BIT_PRESENT = 0;
    localparam int unsigned BIT_SIZE    = 7;

    localparam logic [1:0] REQ_WRITE     = 2'd0;
    localparam logic [1:0] REQ_TRANSLATE = 2'd1;
    localparam logic [1:0] REQ_UNMAP     = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_UNMAPPED = 2'd1;
    localparam logic [1:0] ST_NONCANON = 2'd2;
    localparam logic [1:0] ST_OUTSIDE  = 2'd3;

    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROOT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE = 1'b1;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [14:0] word_index;
        logic [63:0] word_value;
        logic [63:0] virt_addr;
    } t_req;

    typedef struct packed {
        logic [1:0]           status;
        logic [63:0]          phys_addr;
        logic [FLAG_BITS-1:0] page_flags;
        logic                 large_page;
    } t_rsp;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROOT,
        S_PML4,
        S_PDPT,
        S_PD,
        S_PT,
        S_DONE
    } t_state;

endpackage

[hw/rtl/four_level_page_table_walker_top.sv]
// ----------------------------------------------------------------------------
// four_level_page_table_walker_top
// Page table memory with a four-level walker for translate and unmap.
//
// Usage: the request channel (i_in_valid / o_in_stall / i_in) carries one
// beat per request: a table word write, a translate or an unmap. Every
// request gives exactly one result beat on o_out_valid / i_out_stall / o_out.
// Configuration (root table and window base) is written through i_cfg_we,
// i_cfg_index and i_cfg_wdata while no request is in flight.
// Walk: the table memory has one registered read port, and each level of
// the walk costs one read, so the walk is a chain of dependent reads. A walk
// that stops early skips the reads of the levels below it. The result moves
// into the output register from S_DONE once the output slot is free.
// One request is in flight at a time; o_in_stall is high from accept until
// the result has moved into the output register. A stalled output holds its
// beat; the walker finishes the next result and waits behind it.
// Reset clears the control state and both configuration registers. Table
// memory is not cleared: software writes every table word before use.
// ----------------------------------------------------------------------------
module four_level_page_table_walker_top #(
    parameter int unsigned TABLE_PAGES = ptw_pkg::TABLE_PAGES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  ptw_pkg::t_req                  i_in,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output ptw_pkg::t_rsp                  o_out,
    input  logic                           i_cfg_we,
    input  logic [ptw_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [63:0]                    i_cfg_wdata
);
    import ptw_pkg::*;

    localparam int unsigned PW        = $clog2(TABLE_PAGES);
    localparam int unsigned AW        = PW + IDX_BITS;
    localparam int unsigned MEM_WORDS = TABLE_PAGES * ENTRIES_PER_TABLE;
    localparam int unsigned PN_W      = 64 - PAGE_SHIFT;

    logic [63:0]   r_mem [MEM_WORDS];
    logic [63:0]   r_rd_data;

    t_state        r_state, n_state;
    logic [1:0]    r_req_type;
    logic [63:0]   r_virt;
    t_rsp          r_res;
    logic          r_out_valid;
    t_rsp          r_out;
    logic [63:0]   r_root;
    logic [63:0]   r_base;

    logic          in_accept;
    logic          slot_free;
    logic          is_walk_req;

    logic [63:0]   loc_ptr;
    logic [8:0]    loc_idx;
    logic [PN_W-1:0] loc_diff;
    logic          loc_ok;
    logic [AW-1:0] loc_word;

    logic          step_done;
    t_rsp          step_res;
    logic          unmap_we;

    logic [31:0]   widx_ext;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [63:0]   mem_wdata;

    logic          ent_present;
    logic          ent_size;
    logic          is_translate;

    assign in_accept    = i_in_valid && !o_in_stall;
    assign slot_free    = !r_out_valid || !i_out_stall;
    assign is_walk_req  = (i_in.req_type == REQ_TRANSLATE) || (i_in.req_type == REQ_UNMAP);
    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_out        = r_out;
    assign ent_present  = r_rd_data[BIT_PRESENT];
    assign ent_size     = r_rd_data[BIT_SIZE];
    assign is_translate = (r_req_type == REQ_TRANSLATE);

    // Shared table locator: pointer and index of the current level
    always_comb begin
        loc_ptr = (r_state == S_ROOT) ? r_root : r_rd_data;
        case (r_state)
            S_ROOT:  loc_idx = r_virt[L4_LSB +: IDX_BITS];
            S_PML4:  loc_idx = r_virt[L3_LSB +: IDX_BITS];
            S_PDPT:  loc_idx = r_virt[L2_LSB +: IDX_BITS];
            default: loc_idx = r_virt[L1_LSB +: IDX_BITS];
        endcase
        loc_diff = loc_ptr[63:PAGE_SHIFT] - r_base[63:PAGE_SHIFT];
        loc_ok   = (loc_ptr[63:PAGE_SHIFT] >= r_base[63:PAGE_SHIFT])
                && (loc_diff < PN_W'(TABLE_PAGES));
        loc_word = {loc_diff[PW-1:0], loc_idx};
    end

    // Per-level decision and result
    always_comb begin
        step_done = 1'b0;
        step_res  = '0;
        unmap_we  = 1'b0;
        case (r_state)
            S_ROOT: begin
                if ((r_req_type == REQ_UNMAP) && (r_root == '0)) begin
                    step_done       = 1'b1;
                    step_res.status = ST_UNMAPPED;
                end else if (|r_virt[63:CANON_MSB]) begin
                    step_done       = 1'b1;
                    step_res.status = ST_NONCANON;
                end else if (!loc_ok) begin
                    step_done       = 1'b1;
                    step_res.status = ST_OUTSIDE;
                end
            end
            S_PML4, S_PDPT: begin
                if (!ent_present) begin
                    step_done       = 1'b1;
                    step_res.status = ST_UNMAPPED;
                end else if (!loc_ok) begin
                    step_done       = 1'b1;
                    step_res.status = ST_OUTSIDE;
                end
            end
            S_PD: begin
                if (!ent_present) begin
                    step_done       = 1'b1;
                    step_res.status = ST_UNMAPPED;
                end else if (ent_size) begin
                    step_done           = 1'b1;
                    step_res.large_page = 1'b1;
                    if (is_translate) begin
                        step_res.page_flags = r_rd_data[FLAG_BITS-1:0];
                        step_res.phys_addr  = {r_rd_data[63:LARGE_SHIFT],
                                               r_virt[LARGE_SHIFT-1:0]};
                    end else begin
                        step_res.status = ST_UNMAPPED;
                    end
                end else if (!loc_ok) begin
                    step_done       = 1'b1;
                    step_res.status = ST_OUTSIDE;
                end else if (!is_translate) begin
                    // clear the leaf without reading it
                    step_done = 1'b1;
                    unmap_we  = 1'b1;
                end
            end
            S_PT: begin
                step_done = 1'b1;
                if (!ent_present) begin
                    step_res.status = ST_UNMAPPED;
                end else begin
                    step_res.page_flags = r_rd_data[FLAG_BITS-1:0];
                    step_res.phys_addr  = {r_rd_data[63:PAGE_SHIFT],
                                           r_virt[PAGE_SHIFT-1:0]};
                end
            end
            default: begin
                step_done = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_state = is_walk_req ? S_ROOT : S_DONE;
                end
            end
            S_ROOT:  n_state = step_done ? S_DONE : S_PML4;
            S_PML4:  n_state = step_done ? S_DONE : S_PDPT;
            S_PDPT:  n_state = step_done ? S_DONE : S_PD;
            S_PD:    n_state = step_done ? S_DONE : S_PT;
            S_PT:    n_state = S_DONE;
            S_DONE: begin
                if (slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Memory write port: table word writes at accept, leaf clear on unmap
    always_comb begin
        widx_ext  = 32'(i_in.word_index);
        mem_we    = unmap_we
                 || (in_accept && (i_in.req_type == REQ_WRITE) && (widx_ext < 32'(MEM_WORDS)));
        mem_waddr = unmap_we ? loc_word : widx_ext[AW-1:0];
        mem_wdata = unmap_we ? '0 : i_in.word_value;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[loc_word];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_root      <= '0;
            r_base      <= '0;
        end else begin
            r_state <= n_state;
            if ((r_state == S_DONE) && slot_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_ROOT: r_root <= i_cfg_wdata;
                    CFG_BASE: r_base <= i_cfg_wdata;
                    default:  r_root <= r_root;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_req_type <= i_in.req_type;
            r_virt     <= i_in.virt_addr;
            r_res      <= '0;
        end else if (step_done) begin
            r_res <= step_res;
        end
        if ((r_state == S_DONE) && slot_free) begin
            r_out <= r_res;
        end
    end

    // The memory is written only by an accepted write or by the unmap leaf clear
    a_mem_we_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> ((r_state == S_IDLE) || (r_state == S_PD)))
        else $error("table memory written outside a write accept or unmap");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("result beat appeared without a finished walk");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out.status != ST_OK))
            |-> ((o_out.phys_addr == '0) && (o_out.page_flags == '0)))
        else $error("failed request carries an address or flags");

    a_large_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.large_page)
            |-> ((o_out.status == ST_OK) || (o_out.status == ST_UNMAPPED)))
        else $error("large page flagged with a walk error");

endmodule
